>>> hdl/u8u2_pkg.sv
`default_nettype none

package u8u2_pkg;

   localparam int COUNT_BITS_DEFAULT = 16;

   typedef enum logic [2:0] {
      PH_IDLE       = 3'd0,
      PH_TWO_LAST   = 3'd1,
      PH_THREE_MID  = 3'd2,
      PH_THREE_LAST = 3'd3,
      PH_DISCARD    = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      KIND_CHAR  = 2'd0,
      KIND_END   = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] code_unit;
      logic [15:0] byte_count;
   } rsp_word_type;

endpackage

`default_nettype wire

>>> hdl/utf8_to_ucs2_decoder_top.sv
// A result word is written into the response queue when the byte that produces it is accepted.
// Throughput: one byte per cycle; decode is combinational into a
// two-word response queue, so req_ready drops only when that queue is full.
// Reset (synchronous, active high) clears phase, partial code, byte count
// and the response queue.
`default_nettype none

module utf8_to_ucs2_decoder_top #(
   parameter int COUNT_BITS = u8u2_pkg::COUNT_BITS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_in_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_kind,
   output logic [15:0]      rsp_code_unit,
   output logic [15:0]      rsp_byte_count
);

   localparam int WideBits = (COUNT_BITS > 16) ? COUNT_BITS : 16;
   localparam logic [COUNT_BITS-1:0] CountMax = '1;

   u8u2_pkg::phase_type    phase_ff;
   u8u2_pkg::phase_type    phase_in;
   logic [15:0]            partial_ff;
   logic [15:0]            partial_in;
   logic [COUNT_BITS-1:0]  count_ff;
   logic [COUNT_BITS-1:0]  count_in;
   logic [COUNT_BITS-1:0]  count_sat;
   logic [WideBits-1:0]    count_wide;
   logic [WideBits-1:0]    sat_wide;
   logic [15:0]            shown_now;
   logic [15:0]            shown_sat;
   logic                   accept;
   logic                   cont;
   logic                   is_zero;
   logic                   push;
   logic                   full;
   u8u2_pkg::rsp_word_type push_word;
   u8u2_pkg::rsp_word_type head_word;

   assign req_ready = !full;
   assign accept    = req_valid && req_ready;
   assign cont      = (req_in_byte[7:6] == 2'b10);
   assign is_zero   = (req_in_byte == 8'h00);

   assign count_sat  = (count_ff >= CountMax - COUNT_BITS'(1)) ? CountMax
                                                               : count_ff + COUNT_BITS'(2);
   assign count_wide = WideBits'(count_ff);
   assign sat_wide   = WideBits'(count_sat);
   assign shown_now  = (count_wide > WideBits'(16'hFFFF)) ? 16'hFFFF : count_wide[15:0];
   assign shown_sat  = (sat_wide > WideBits'(16'hFFFF)) ? 16'hFFFF : sat_wide[15:0];

   always_comb begin
      phase_in             = phase_ff;
      partial_in           = partial_ff;
      count_in             = count_ff;
      push                 = 1'b0;
      push_word.kind       = u8u2_pkg::KIND_ERROR;
      push_word.code_unit  = 16'h0000;
      push_word.byte_count = shown_now;
      case (phase_ff)
         u8u2_pkg::PH_TWO_LAST, u8u2_pkg::PH_THREE_LAST: begin
            push = 1'b1;
            if (cont) begin
               push_word.kind       = u8u2_pkg::KIND_CHAR;
               push_word.code_unit  = partial_ff | {10'b0, req_in_byte[5:0]};
               push_word.byte_count = shown_sat;
               count_in             = count_sat;
               phase_in             = u8u2_pkg::PH_IDLE;
               partial_in           = 16'h0000;
            end else begin
               partial_in = 16'h0000;
               if (is_zero) begin
                  phase_in = u8u2_pkg::PH_IDLE;
                  count_in = '0;
               end else begin
                  phase_in = u8u2_pkg::PH_DISCARD;
               end
            end
         end
         u8u2_pkg::PH_THREE_MID: begin
            if (cont) begin
               partial_in = partial_ff | {4'b0, req_in_byte[5:0], 6'b0};
               phase_in   = u8u2_pkg::PH_THREE_LAST;
            end else begin
               push       = 1'b1;
               partial_in = 16'h0000;
               if (is_zero) begin
                  phase_in = u8u2_pkg::PH_IDLE;
                  count_in = '0;
               end else begin
                  phase_in = u8u2_pkg::PH_DISCARD;
               end
            end
         end
         u8u2_pkg::PH_DISCARD: begin
            if (is_zero) begin
               phase_in   = u8u2_pkg::PH_IDLE;
               partial_in = 16'h0000;
               count_in   = '0;
            end
         end
         default: begin
            if (is_zero) begin
               push           = 1'b1;
               push_word.kind = u8u2_pkg::KIND_END;
               phase_in       = u8u2_pkg::PH_IDLE;
               partial_in     = 16'h0000;
               count_in       = '0;
            end else if (!req_in_byte[7]) begin
               push                 = 1'b1;
               push_word.kind       = u8u2_pkg::KIND_CHAR;
               push_word.code_unit  = {8'h00, req_in_byte};
               push_word.byte_count = shown_sat;
               count_in             = count_sat;
               phase_in             = u8u2_pkg::PH_IDLE;
               partial_in           = 16'h0000;
            end else if (req_in_byte[7:5] == 3'b110) begin
               partial_in = {5'b0, req_in_byte[4:0], 6'b0};
               phase_in   = u8u2_pkg::PH_TWO_LAST;
            end else if (req_in_byte[7:4] == 4'b1110) begin
               partial_in = {req_in_byte[3:0], 12'b0};
               phase_in   = u8u2_pkg::PH_THREE_MID;
            end else begin
               push       = 1'b1;
               partial_in = 16'h0000;
               phase_in   = u8u2_pkg::PH_DISCARD;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= u8u2_pkg::PH_IDLE;
         partial_ff <= 16'h0000;
         count_ff   <= '0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         partial_ff <= partial_in;
         count_ff   <= count_in;
      end
   end

   u8u2_rsp_fifo rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (accept && push),
      .push_word  (push_word),
      .full       (full),
      .pop        (rsp_ready),
      .head_valid (rsp_valid),
      .head_word  (head_word)
   );

   assign rsp_kind       = head_word.kind;
   assign rsp_code_unit  = head_word.code_unit;
   assign rsp_byte_count = head_word.byte_count;

`ifndef SYNTHESIS
   a_code_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind != u8u2_pkg::KIND_CHAR)) |-> (rsp_code_unit == 16'h0000))
      else $error("end or error word with nonzero code unit");
   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind == u8u2_pkg::KIND_CHAR || rsp_kind == u8u2_pkg::KIND_END ||
                     rsp_kind == u8u2_pkg::KIND_ERROR))
      else $error("illegal response kind");
   a_discard_hold: assert property (@(posedge clock) disable iff (reset)
      (accept && (phase_ff == u8u2_pkg::PH_DISCARD) && !is_zero) |=>
      (phase_ff == u8u2_pkg::PH_DISCARD))
      else $error("left discard before zero byte");
   a_discard_quiet: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == u8u2_pkg::PH_DISCARD) |-> !push)
      else $error("response produced while discarding");
`endif

endmodule

`default_nettype wire

>>> hdl/u8u2_rsp_fifo.sv
`default_nettype none

module u8u2_rsp_fifo (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire u8u2_pkg::rsp_word_type push_word,
   output logic                        full,
   input  wire logic                   pop,
   output logic                        head_valid,
   output u8u2_pkg::rsp_word_type      head_word
);

   u8u2_pkg::rsp_word_type entry_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       do_pop;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_word  = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("push into full response queue");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("response queue count out of range");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd1) |-> (wr_ptr_ff != rd_ptr_ff))
      else $error("response queue pointers disagree with count");
`endif

endmodule

`default_nettype wire

>>> tb/tb_utf8_to_ucs2_decoder_top.sv
module tb_utf8_to_ucs2_decoder_top;

   localparam int CNT_W = u8u2_pkg::COUNT_BITS_DEFAULT;
   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [7:0] req_in_byte = 8'h00;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_kind;
   logic [15:0] rsp_code_unit;
   logic [15:0] rsp_byte_count;

   u8u2_pkg::phase_type dec_phase = u8u2_pkg::PH_IDLE;
   logic [15:0] dec_code = '0;
   logic [CNT_W-1:0] dec_count = '0;

   u8u2_pkg::rsp_word_type pending_words[$];
   u8u2_pkg::rsp_word_type want_word;
   int error_count = 0;
   int live_bytes = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_off_cycles = 0;

   utf8_to_ucs2_decoder_top u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_in_byte(req_in_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_kind(rsp_kind),
      .rsp_code_unit(rsp_code_unit),
      .rsp_byte_count(rsp_byte_count)
   );

   always #4 clock = ~clock;

   function automatic logic [15:0] shown_count();
      if (longint'(dec_count) > 64'hFFFF) return 16'hFFFF;
      return 16'(dec_count);
   endfunction

   function automatic u8u2_pkg::rsp_word_type finish_char(input logic [15:0] code);
      u8u2_pkg::rsp_word_type w;
      dec_count = (dec_count >= CNT_MAX - CNT_W'(1)) ? CNT_MAX : dec_count + CNT_W'(2);
      dec_phase = u8u2_pkg::PH_IDLE;
      dec_code = '0;
      w.kind = u8u2_pkg::KIND_CHAR;
      w.code_unit = code;
      w.byte_count = shown_count();
      return w;
   endfunction

   function automatic u8u2_pkg::rsp_word_type raise_error(input logic [7:0] b);
      u8u2_pkg::rsp_word_type w;
      w.kind = u8u2_pkg::KIND_ERROR;
      w.code_unit = '0;
      w.byte_count = shown_count();
      dec_code = '0;
      if (b == 8'h00) begin
         dec_phase = u8u2_pkg::PH_IDLE;
         dec_count = '0;
      end else begin
         dec_phase = u8u2_pkg::PH_DISCARD;
      end
      return w;
   endfunction

   function automatic void decode_byte(input logic [7:0] b, output bit produced,
                                       output bit dropped,
                                       output u8u2_pkg::rsp_word_type w);
      bit cont;
      cont = (b[7:6] == 2'b10);
      produced = 1'b1;
      dropped = 1'b0;
      w = '0;
      case (dec_phase)
         u8u2_pkg::PH_TWO_LAST, u8u2_pkg::PH_THREE_LAST: begin
            if (!cont) w = raise_error(b);
            else w = finish_char(dec_code | {10'd0, b[5:0]});
         end
         u8u2_pkg::PH_THREE_MID: begin
            produced = 1'b0;
            if (!cont) begin
               w = raise_error(b);
               produced = 1'b1;
            end else begin
               dec_code = dec_code | {4'd0, b[5:0], 6'd0};
               dec_phase = u8u2_pkg::PH_THREE_LAST;
            end
         end
         u8u2_pkg::PH_DISCARD: begin
            produced = 1'b0;
            dropped = 1'b1;
            if (b == 8'h00) begin
               dec_phase = u8u2_pkg::PH_IDLE;
               dec_code = '0;
               dec_count = '0;
            end
         end
         default: begin
            if (b == 8'h00) begin
               w.kind = u8u2_pkg::KIND_END;
               w.code_unit = '0;
               w.byte_count = shown_count();
               dec_phase = u8u2_pkg::PH_IDLE;
               dec_code = '0;
               dec_count = '0;
            end else if (b <= 8'h7F) begin
               w = finish_char({8'd0, b});
            end else if (b[7:5] == 3'b110) begin
               produced = 1'b0;
               dec_code = {5'd0, b[4:0], 6'd0};
               dec_phase = u8u2_pkg::PH_TWO_LAST;
            end else if (b[7:4] == 4'b1110) begin
               produced = 1'b0;
               dec_code = {b[3:0], 12'd0};
               dec_phase = u8u2_pkg::PH_THREE_MID;
            end else begin
               w = raise_error(b);
            end
         end
      endcase
   endfunction

   // hold valid until accepted, then predict
   task automatic push_byte(input logic [7:0] b);
      bit produced;
      bit dropped;
      u8u2_pkg::rsp_word_type w;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_in_byte = b;
      do @(posedge clock); while (!req_ready);
      decode_byte(b, produced, dropped, w);
      if (produced) pending_words.push_back(w);
      if (!dropped) live_bytes++;
   endtask

   task automatic stop_sending();
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic wait_for_drain();
      stop_sending();
      while (pending_words.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] cont_byte();
      return 8'h80 | 8'($urandom_range(0, 63));
   endfunction

   function automatic logic [7:0] non_cont_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (b[7:6] == 2'b10);
      return b;
   endfunction

   function automatic logic [7:0] bad_lead();
      if ($urandom_range(1)) return 8'($urandom_range(8'h80, 8'hBF));
      return 8'($urandom_range(8'hF0, 8'hFF));
   endfunction

   task automatic test_directed();
      logic [7:0] seq[] = '{8'h01, 8'h7F, 8'hC2, 8'h80, 8'hDF, 8'hBF,
                            8'hE0, 8'h80, 8'h80, 8'hEF, 8'hBF, 8'hBF,
                            8'hED, 8'hA0, 8'h80, 8'h00, 8'h00,
                            8'h80, 8'hC2, 8'h00, 8'hF0, 8'h00,
                            8'hC2, 8'h41, 8'h00, 8'hE2, 8'h82, 8'h00,
                            8'hFF, 8'h00};
      foreach (seq[i]) push_byte(seq[i]);
   endtask

   task automatic test_random_strings(input int target);
      int start;
      int nchars;
      int pick;
      start = live_bytes;
      while (live_bytes - start < target) begin
         nchars = $urandom_range(0, 10);
         repeat (nchars) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
               push_byte(8'($urandom_range(1, 127)));
            end else if (pick < 60) begin
               push_byte(8'hC0 | 8'($urandom_range(0, 31)));
               push_byte(cont_byte());
            end else if (pick < 80) begin
               push_byte(8'hE0 | 8'($urandom_range(0, 15)));
               push_byte(cont_byte());
               push_byte(cont_byte());
            end else if (pick < 86) begin
               push_byte(bad_lead());
            end else if (pick < 94) begin
               if ($urandom_range(1)) begin
                  push_byte(8'hC0 | 8'($urandom_range(0, 31)));
               end else begin
                  push_byte(8'hE0 | 8'($urandom_range(0, 15)));
                  if ($urandom_range(1)) push_byte(cont_byte());
               end
               push_byte($urandom_range(3) == 0 ? 8'h00 : non_cont_byte());
            end else begin
               push_byte(8'($urandom_range(0, 255)));
            end
         end
         push_byte(8'h00);
         if ($urandom_range(99) < 3) wait_for_drain();
      end
   endtask

   // stall the receiver long enough for the response queue to fill
   task automatic test_backpressure();
      hold_off_cycles = 200;
      repeat (40) push_byte(8'($urandom_range(1, 127)));
      push_byte(8'h00);
      wait_for_drain();
   endtask

   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         rsp_ready = 1'b0;
         hold_off_cycles = hold_off_cycles - 1;
      end else begin
         rsp_ready = ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_words.size() == 0) begin
            if (error_count < 10)
               $display("unexpected word: kind=%0d code=%h count=%h",
                        rsp_kind, rsp_code_unit, rsp_byte_count);
            error_count++;
         end else begin
            want_word = pending_words.pop_front();
            if (rsp_kind !== want_word.kind || rsp_code_unit !== want_word.code_unit ||
                rsp_byte_count !== want_word.byte_count) begin
               if (error_count < 10)
                  $display("mismatch: kind %0d/%0d code %h/%h count %h/%h (want/got)",
                           want_word.kind, rsp_kind, want_word.code_unit, rsp_code_unit,
                           want_word.byte_count, rsp_byte_count);
               error_count++;
            end
         end
      end
   end

   initial begin
      #4000000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_idle_pct = 20;
      recv_idle_pct = 57;
      test_directed();
      test_random_strings(150);
      test_backpressure();

      send_idle_pct = 57;
      recv_idle_pct = 20;
      test_random_strings(150);
      wait_for_drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_strings(140);

      wait_for_drain();
      repeat (10) @(posedge clock);
      if (pending_words.size() != 0) error_count++;
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
hdl/u8u2_pkg.sv
hdl/u8u2_rsp_fifo.sv
hdl/utf8_to_ucs2_decoder_top.sv
tb/tb_utf8_to_ucs2_decoder_top.sv
